FILE: src/ildt_pkg.sv
// Shared types and constants for the instruction dependency level tagger.
// No dependencies; imported by the level table, the sequencer and the top level.
package ildt_pkg;

  localparam int NUM_REGS     = 256;
  localparam int LEVEL_BITS   = 16;
  localparam int REG_IDX_BITS = $clog2(NUM_REGS);

  localparam logic [7:0] EMPTY_SLOT = 8'hff;
  localparam logic [7:0] DST3_MARK  = 8'hfe;
  localparam int         LEVEL_SHIFT = 48;

  typedef logic [LEVEL_BITS-1:0]   level_t;
  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  localparam level_t LEVEL_MAX = '1;

  // level table port group
  typedef struct packed {
    logic     wr_en;
    reg_idx_t wr_addr;
    level_t   wr_data;
    reg_idx_t rd_addr;
  } ram_req_t;

  // finished result handed to the output register
  typedef struct packed {
    logic        valid;
    logic [63:0] tag_word;
    logic [15:0] level;
    logic        fin;
  } result_t;

endpackage

FILE: src/ildt_level_ram.sv
// Register level table: one write port, one registered read port.
// Depends on ildt_pkg.
module ildt_level_ram
  import ildt_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output level_t   rd_data
);

  level_t mem [NUM_REGS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

FILE: src/ildt_seq.sv
// Per-instruction sequencer: walks the four register bytes through the level
// table, tracks valid bits, barrier floor and table maximum. Depends on ildt_pkg.
module ildt_seq
  import ildt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_word,
  input  logic        in_clear,
  input  logic        in_fin,
  input  logic        slot_free,
  output result_t     res,
  output ram_req_t    ram_req,
  input  level_t      rd_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t              state;
  logic [1:0]          cnt;
  logic [63:0]         word_q;
  logic                fin_q;
  level_t              level;
  level_t              floor_lvl;
  level_t              max_lvl;
  logic [NUM_REGS-1:0] valid;
  logic                lw_valid;
  reg_idx_t            lw_addr;
  level_t              lw_val;

  logic       accept;
  logic       barrier;
  logic [1:0] src;
  logic [1:0] nxt_cnt;
  logic [7:0] cur_byte;
  logic [7:0] nxt_byte;
  reg_idx_t   cur_idx;
  logic       cur_used;
  logic       in_range;
  level_t     raw;
  level_t     eff;
  level_t     lvl_new;
  level_t     wval;
  logic       is_dst;
  logic       finish;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign barrier  = (in_word[63:16] == '1);

  assign src      = (word_q[47:40] == DST3_MARK) ? 2'd3 : 2'd2;
  assign nxt_cnt  = cnt + 2'd1;
  assign cur_byte = word_q[16 + 8*cnt +: 8];
  assign nxt_byte = word_q[16 + 8*nxt_cnt +: 8];
  assign cur_idx  = cur_byte[REG_IDX_BITS-1:0];
  assign cur_used = (cur_byte != EMPTY_SLOT);
  assign in_range = (9'(cur_byte) < 9'(NUM_REGS));

  always_comb begin
    // byte 3 may hit the entry byte 2 wrote while its read was in flight
    if (lw_valid && lw_addr == cur_idx) begin
      raw = lw_val;
    end else if (valid[cur_idx]) begin
      raw = rd_data;
    end else begin
      raw = '0;
    end
    if (!in_range) begin
      eff = '0;
    end else begin
      eff = (raw > floor_lvl) ? raw : floor_lvl;
    end
    lvl_new = (cur_used && eff > level) ? eff : level;
    wval    = (lvl_new == LEVEL_MAX) ? LEVEL_MAX : lvl_new + level_t'(1);
    is_dst  = (state == S_RUN) && cur_used && in_range && (cnt >= src);
  end

  always_comb begin
    ram_req.wr_en   = is_dst;
    ram_req.wr_addr = cur_idx;
    ram_req.wr_data = wval;
    if (state == S_IDLE) begin
      ram_req.rd_addr = in_word[16 +: REG_IDX_BITS];
    end else begin
      ram_req.rd_addr = nxt_byte[REG_IDX_BITS-1:0];
    end
  end

  assign finish = slot_free && ((state == S_DONE) || (state == S_RUN && cnt == 2'd3));

  always_comb begin
    res.valid    = finish;
    res.level    = 16'((state == S_RUN) ? lvl_new : level);
    res.tag_word = {res.level, word_q[LEVEL_SHIFT-1:0]};
    res.fin      = fin_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 2'd0;
      floor_lvl <= '0;
      max_lvl   <= '0;
      valid     <= '0;
      lw_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            word_q   <= in_word;
            fin_q    <= in_fin;
            cnt      <= 2'd0;
            lw_valid <= 1'b0;
            if (in_clear) begin
              valid <= '0;
            end
            if (barrier) begin
              level     <= in_clear ? '0 : max_lvl;
              floor_lvl <= in_clear ? '0 : max_lvl;
              if (in_clear) begin
                max_lvl <= '0;
              end
              state <= S_DONE;
            end else begin
              level <= '0;
              if (in_clear) begin
                floor_lvl <= '0;
                max_lvl   <= '0;
              end
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          level    <= lvl_new;
          cnt      <= nxt_cnt;
          lw_valid <= is_dst;
          lw_addr  <= cur_idx;
          lw_val   <= wval;
          if (is_dst) begin
            valid[cur_idx] <= 1'b1;
            if (wval > max_lvl) begin
              max_lvl <= wval;
            end
          end
          if (cnt == 2'd3) begin
            state <= slot_free ? S_IDLE : S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/instruction_dependency_level_tagger_core.sv
// Instruction dependency level tagger: top level with the output register.
// Depends on ildt_pkg, ildt_level_ram and ildt_seq.
//
// Input stream (s_*): one request per instruction. tdata carries the 64-bit
// instruction word, tuser asks for the level table to be cleared before the
// word is handled, tlast marks the last instruction of a code block.
// Output stream (m_*): one result per request, in order. tdata carries the
// tagged word (low 64 bits) and the 16-bit issue level; tlast echoes the mark.
// Timing: an ordinary instruction reads its four register bytes from the level
// table one per cycle (single read port, registered read); the result is
// registered after the last byte, and only then is the next request taken.
// A barrier word uses the tracked table maximum and floor instead of reads:
// its result is registered from the done state, then the next request is taken.
// s_tready is high only while the sequencer is idle; a finished result sits in
// the output register, so a stalled receiver holds m_tdata steady and the next
// request can still be accepted and worked on until its own result is ready.
// Reset clears the valid bits, floor and maximum at once: the table reads as
// all zero from the first cycle after reset, with no clearing pass.
module instruction_dependency_level_tagger_core
  import ildt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // instr_word
  input  logic        s_tuser,   // clear_first
  input  logic        s_tlast,   // final_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // tagged_word [63:0], issue_level [79:64]
  output logic        m_tlast    // final_out
);

  ram_req_t ram_req;
  level_t   rd_data;
  result_t  res;
  logic     slot_free;

  assign slot_free = !m_tvalid || m_tready;

  ildt_level_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  ildt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_word   (s_tdata),
    .in_clear  (s_tuser),
    .in_fin    (s_tlast),
    .slot_free (slot_free),
    .res       (res),
    .ram_req   (ram_req),
    .rd_data   (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res.valid) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {res.level, res.tag_word};
        m_tlast  <= res.fin;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/ildt_checker.sv
// Port-level checks for the dependency level tagger, bound to the top level.
// Depends only on the top-level port list.
module ildt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  // stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // level field and tagged word upper bits agree
  a_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[79:64] == m_tdata[63:48])
    else $error("issue level mismatch in tagged word");

  // one request in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // no result can appear the cycle right after an accept
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result too early");

endmodule

bind instruction_dependency_level_tagger_core ildt_checker u_chk (.*);
